// ----- hdl/pts_pkg.sv -----
package pts_pkg;

  localparam int MAX_FEATURES_DEF  = 16;
  localparam int VALUE_WIDTH_DEF   = 16;
  localparam int ACC_WIDTH         = 40;
  localparam int FRAC_BITS         = 12;
  localparam int RATE_BITS         = 16;
  localparam int RATE_W            = 16;
  localparam int COUNT_W           = 5;
  localparam int CMD_W             = 2;
  localparam int INDEX_W           = 4;
  localparam int ERR_W             = 2;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 16;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd6554;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd2;

  localparam logic [CMD_W-1:0] CMD_TRAIN       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_BIAS   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_COUNT = 2'd1;

  typedef struct packed {
    logic train;
    logic load_weight;
    logic load_bias;
    logic mul;
    logic acc;
    logic sum;
    logic scale;
    logic bias_upd;
    logic walk_rd;
    logic walk_mul;
    logic walk_wr;
  } pts_cmd_t;

  typedef struct packed {
    logic sample_end;
    logic walk_last;
  } pts_status_t;

endpackage

// ----- hdl/pts_ram.sv -----
module pts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/pts_ctrl.sv -----
module pts_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [pts_pkg::CMD_W-1:0]  cmd,
  output logic                       result_valid,
  input  logic                       result_stall,
  output pts_pkg::pts_cmd_t          ctrl,
  input  pts_pkg::pts_status_t       status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_BIAS  = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WMUL  = 4'd7;
  localparam logic [3:0] S_WUPD  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       result_valid_next;
  logic       out_free;
  logic       accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  // the output register frees up in the same cycle its transaction completes
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            pts_pkg::CMD_TRAIN: begin
              ctrl.train = 1'b1;
              state_next = S_MUL;
            end
            pts_pkg::CMD_LOAD_WEIGHT: ctrl.load_weight = 1'b1;
            pts_pkg::CMD_LOAD_BIAS:   ctrl.load_bias = 1'b1;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        ctrl.mul   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctrl.acc   = 1'b1;
        state_next = status.sample_end ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        ctrl.sum   = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        ctrl.scale = 1'b1;
        state_next = S_BIAS;
      end
      S_BIAS: begin
        ctrl.bias_upd = 1'b1;
        state_next    = S_WRD;
      end
      S_WRD: begin
        ctrl.walk_rd = 1'b1;
        state_next   = S_WMUL;
      end
      S_WMUL: begin
        ctrl.walk_mul = 1'b1;
        state_next    = S_WUPD;
      end
      S_WUPD: begin
        // hold until the previous result has left
        if (out_free) begin
          ctrl.walk_wr = 1'b1;
          state_next   = status.walk_last ? S_IDLE : S_WRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (ctrl.walk_wr) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

// ----- hdl/pts_datapath.sv -----
module pts_datapath #(
  parameter int MAX_FEATURES = pts_pkg::MAX_FEATURES_DEF,
  parameter int VALUE_WIDTH  = pts_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pts_pkg::pts_cmd_t                   ctrl,
  output pts_pkg::pts_status_t                status,
  input  logic                                cfg_wr,
  input  logic [pts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [VALUE_WIDTH-1:0]       feature_value,
  input  logic                                target,
  input  logic [pts_pkg::INDEX_W-1:0]         weight_index,
  input  logic signed [VALUE_WIDTH-1:0]       init_value,
  output logic [pts_pkg::INDEX_W-1:0]         out_index,
  output logic signed [VALUE_WIDTH-1:0]       weight_value,
  output logic signed [VALUE_WIDTH-1:0]       bias_value,
  output logic                                prediction,
  output logic signed [pts_pkg::ERR_W-1:0]    error_value,
  output logic                                last_result
);

  localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int ER_W  = pts_pkg::RATE_W + 2;
  localparam int PW    = VALUE_WIDTH + ER_W;
  localparam int ACC_W = pts_pkg::ACC_WIDTH;

  // configuration
  logic [pts_pkg::RATE_W-1:0]  step_rate;
  logic [pts_pkg::COUNT_W-1:0] feature_count;

  // control state
  logic [IDX_W-1:0]        counter;
  logic [IDX_W-1:0]        last_idx;
  logic [IDX_W-1:0]        walk_idx;
  logic                    sample_end;
  logic [ACC_W-1:0]        acc;
  logic signed [VALUE_WIDTH-1:0] bias;
  logic [MAX_FEATURES-1:0] weight_valid;
  logic                    rd_valid;

  // payload
  logic signed [VALUE_WIDTH-1:0]   feat_q;
  logic                            target_q;
  logic signed [2*VALUE_WIDTH-1:0] prod_acc;
  logic                            pred_q;
  logic signed [pts_pkg::ERR_W-1:0] err_q;
  logic signed [ER_W-1:0]          err_rate;
  logic signed [PW-1:0]            walk_prod;
  logic signed [VALUE_WIDTH-1:0]   walk_w;

  // combinational
  logic [CNT_W-1:0]              n_clamp;
  logic [CNT_W-1:0]              pos_inc;
  logic                          more;
  logic                          idx_ok;
  logic                          w_wr_en;
  logic [IDX_W-1:0]              w_wr_addr;
  logic [VALUE_WIDTH-1:0]        w_wr_data;
  logic                          w_rd_en;
  logic [IDX_W-1:0]              w_rd_addr;
  logic [VALUE_WIDTH-1:0]        w_rd_data;
  logic [VALUE_WIDTH-1:0]        f_rd_data;
  logic signed [VALUE_WIDTH-1:0] w_eff;
  logic [ACC_W-1:0]              bias_shift;
  logic [ACC_W-1:0]              total;
  logic                          pred;
  logic signed [ER_W-1:0]        rate_s;
  logic signed [PW-1:0]          b_sum;
  logic signed [PW-1:0]          w_sum;
  logic signed [VALUE_WIDTH-1:0] bias_new;
  logic signed [VALUE_WIDTH-1:0] w_new;

  function automatic logic signed [VALUE_WIDTH-1:0] sat_value(input logic signed [PW-1:0] v);
    logic fits;
    fits = (&v[PW-1:VALUE_WIDTH-1]) || !(|v[PW-1:VALUE_WIDTH-1]);
    if (fits) begin
      return v[VALUE_WIDTH-1:0];
    end else if (v[PW-1]) begin
      return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  // a count of zero acts as one, anything beyond the store acts as the store size
  always_comb begin
    if (feature_count == '0) begin
      n_clamp = CNT_W'(1);
    end else if (int'(feature_count) > MAX_FEATURES) begin
      n_clamp = CNT_W'(MAX_FEATURES);
    end else begin
      n_clamp = CNT_W'(feature_count);
    end
  end

  assign pos_inc = CNT_W'(counter) + CNT_W'(1);
  assign more    = (pos_inc < n_clamp);
  assign idx_ok  = (int'(weight_index) < MAX_FEATURES);

  assign w_wr_en   = (ctrl.load_weight && idx_ok) || ctrl.walk_wr;
  assign w_wr_addr = ctrl.walk_wr ? walk_idx : IDX_W'(weight_index);
  assign w_wr_data = ctrl.walk_wr ? w_new : init_value;
  assign w_rd_en   = ctrl.train || ctrl.walk_rd;
  assign w_rd_addr = ctrl.walk_rd ? walk_idx : counter;
  assign w_eff     = rd_valid ? signed'(w_rd_data) : '0;

  pts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_FEATURES)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (w_wr_data),
    .rd_en   (w_rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd_data)
  );

  pts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_FEATURES)
  ) u_feature_ram (
    .clk     (clk),
    .wr_en   (ctrl.train),
    .wr_addr (counter),
    .wr_data (feature_value),
    .rd_en   (ctrl.walk_rd),
    .rd_addr (walk_idx),
    .rd_data (f_rd_data)
  );

  // bias lines up with the Q8.24 products before the add; both wrap at the accumulator width
  assign bias_shift = ACC_W'(bias) << pts_pkg::FRAC_BITS;
  assign total      = acc + bias_shift;
  assign pred       = !total[ACC_W-1] && (|total);
  assign rate_s     = signed'({2'b00, step_rate});

  // arithmetic shifts floor toward minus infinity
  assign b_sum    = PW'(bias) + PW'(err_rate >>> (pts_pkg::RATE_BITS - pts_pkg::FRAC_BITS));
  assign bias_new = sat_value(b_sum);
  assign w_sum    = PW'(walk_w) + (walk_prod >>> pts_pkg::RATE_BITS);
  assign w_new    = sat_value(w_sum);

  assign status.sample_end = sample_end;
  assign status.walk_last  = (walk_idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate     <= pts_pkg::RATE_RESET;
      feature_count <= pts_pkg::COUNT_RESET;
      counter       <= '0;
      last_idx      <= '0;
      walk_idx      <= '0;
      sample_end    <= 1'b0;
      acc           <= '0;
      bias          <= '0;
      weight_valid  <= '0;
      rd_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          pts_pkg::REG_STEP_RATE:     step_rate <= cfg_data[pts_pkg::RATE_W-1:0];
          pts_pkg::REG_FEATURE_COUNT: feature_count <= cfg_data[pts_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (w_wr_en) begin
        weight_valid[w_wr_addr] <= 1'b1;
      end
      if (w_rd_en) begin
        rd_valid <= weight_valid[w_rd_addr];
      end
      if (ctrl.train) begin
        if (more) begin
          counter    <= IDX_W'(pos_inc);
          sample_end <= 1'b0;
        end else begin
          counter    <= '0;
          last_idx   <= counter;
          sample_end <= 1'b1;
        end
      end
      if (ctrl.acc) begin
        acc <= acc + ACC_W'(prod_acc);
      end
      if (ctrl.load_bias) begin
        bias <= init_value;
      end
      if (ctrl.bias_upd) begin
        bias     <= bias_new;
        acc      <= '0;
        walk_idx <= '0;
      end
      if (ctrl.walk_wr) begin
        walk_idx <= walk_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.train) begin
      feat_q   <= feature_value;
      target_q <= target;
    end
    if (ctrl.mul) begin
      prod_acc <= w_eff * feat_q;
    end
    if (ctrl.sum) begin
      pred_q <= pred;
      err_q  <= signed'({1'b0, target_q} - {1'b0, pred});
    end
    if (ctrl.scale) begin
      if (err_q[1]) begin
        err_rate <= -rate_s;
      end else if (err_q[0]) begin
        err_rate <= rate_s;
      end else begin
        err_rate <= '0;
      end
    end
    if (ctrl.walk_mul) begin
      walk_prod <= err_rate * signed'(f_rd_data);
      walk_w    <= w_eff;
    end
    if (ctrl.walk_wr) begin
      out_index    <= pts_pkg::INDEX_W'(walk_idx);
      weight_value <= w_new;
      bias_value   <= bias;
      prediction   <= pred_q;
      error_value  <= err_q;
      last_result  <= status.walk_last;
    end
  end

endmodule

// ----- hdl/perceptron_training_step.sv -----
// After a load item the block takes the next item in the following cycle.
// A train feature passes through weight read, multiply and accumulate steps.
// The last feature of a sample adds sum, scale and bias update steps, then the
// weight walk issues one result per feature (read, multiply, update) unless stalled.
// Synchronous reset clears weights (by valid bits), bias, accumulator, counter and
// restores the learning rate to 6554 and the feature count to 2.
module perceptron_training_step #(
  parameter int MAX_FEATURES = pts_pkg::MAX_FEATURES_DEF,
  parameter int VALUE_WIDTH  = pts_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [pts_pkg::CMD_W-1:0]        cmd,
  input  logic signed [VALUE_WIDTH-1:0]    feature_value,
  input  logic                             target,
  input  logic [pts_pkg::INDEX_W-1:0]      weight_index,
  input  logic signed [VALUE_WIDTH-1:0]    init_value,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [pts_pkg::INDEX_W-1:0]      out_index,
  output logic signed [VALUE_WIDTH-1:0]    weight_value,
  output logic signed [VALUE_WIDTH-1:0]    bias_value,
  output logic                             prediction,
  output logic signed [pts_pkg::ERR_W-1:0] error_value,
  output logic                             last_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pts_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pts_pkg::pts_cmd_t    ctrl;
  pts_pkg::pts_status_t status;

  assign cfg_ready = 1'b1;

  pts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctrl         (ctrl),
    .status       (status)
  );

  pts_datapath #(
    .MAX_FEATURES (MAX_FEATURES),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .feature_value (feature_value),
    .target        (target),
    .weight_index  (weight_index),
    .init_value    (init_value),
    .out_index     (out_index),
    .weight_value  (weight_value),
    .bias_value    (bias_value),
    .prediction    (prediction),
    .error_value   (error_value),
    .last_result   (last_result)
  );

endmodule

// ----- hdl/pts_checker.sv -----
module pts_checker #(
  parameter int VALUE_WIDTH = pts_pkg::VALUE_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_stall,
  input logic [pts_pkg::CMD_W-1:0]        cmd,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [pts_pkg::INDEX_W-1:0]      out_index,
  input logic signed [VALUE_WIDTH-1:0]    weight_value,
  input logic                             prediction,
  input logic signed [pts_pkg::ERR_W-1:0] error_value,
  input logic                             last_result
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_index)
      && $stable(weight_value) && $stable(last_result))
    else $error("stalled result transaction changed");

  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |-> item_stall)
    else $error("input taken in the middle of a result run");

  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (cmd == pts_pkg::CMD_LOAD_WEIGHT
      || cmd == pts_pkg::CMD_LOAD_BIAS) |=> !item_stall)
    else $error("load transaction stalled the next item");

  a_error_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (error_value != 2'b10)
      && !(error_value == 2'b01 && prediction)
      && !(error_value == 2'b11 && !prediction))
    else $error("error value inconsistent with prediction");

endmodule

bind perceptron_training_step pts_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pts_checker (.*);

// ----- tb/sv/perceptron_training_step_tb.sv -----
module perceptron_training_step_tb;

  localparam int MAXF          = pts_pkg::MAX_FEATURES_DEF;
  localparam int VW            = pts_pkg::VALUE_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 40;
  localparam int PHASES        = 8;

  localparam logic [pts_pkg::CMD_W-1:0]       CMD_UNUSED = 2'd3;
  localparam logic [pts_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [pts_pkg::INDEX_W-1:0]    idx;
    logic signed [VW-1:0]           weight;
    logic signed [VW-1:0]           bias;
    logic                           pred;
    logic signed [pts_pkg::ERR_W-1:0] err;
    logic                           last;
  } weight_update_t;

  // Tracks weights, bias and the running dot product; queues the weight run each
  // completed sample should produce.
  class weight_update_tracker;
    logic [pts_pkg::RATE_W-1:0]    rate;
    logic [pts_pkg::COUNT_W-1:0]   count;
    logic signed [VW-1:0]          weights[MAXF];
    logic signed [VW-1:0]          bias_reg;
    logic signed [VW-1:0]          feats[MAXF];
    logic [pts_pkg::COUNT_W-1:0]   fcount;
    logic [pts_pkg::ACC_WIDTH-1:0] acc;
    weight_update_t       expected_updates[$];
    int mismatches;
    int items_taken;
    int updates_seen;
    int samples_done;
    int reg_writes;

    function new();
      rate = pts_pkg::RATE_RESET;
      count = pts_pkg::COUNT_RESET;
      foreach (weights[i]) begin
        weights[i] = '0;
        feats[i] = '0;
      end
      bias_reg = '0;
      fcount = '0;
      acc = '0;
      mismatches = 0;
      items_taken = 0;
      updates_seen = 0;
      samples_done = 0;
      reg_writes = 0;
    endfunction

    function logic signed [VW-1:0] clamp(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[VW-1:0];
    endfunction

    function void set_reg(logic [pts_pkg::CFG_INDEX_W-1:0] idx,
                          logic [pts_pkg::CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == pts_pkg::REG_STEP_RATE) rate = data[pts_pkg::RATE_W-1:0];
      else if (idx == pts_pkg::REG_FEATURE_COUNT) count = data[pts_pkg::COUNT_W-1:0];
    endfunction

    function void take_item(logic [pts_pkg::CMD_W-1:0] c, logic signed [VW-1:0] f, logic t,
                            logic [pts_pkg::INDEX_W-1:0] wi, logic signed [VW-1:0] iv);
      int n;
      int pos;
      int i;
      int pred;
      int err;
      longint s;
      longint p;
      weight_update_t u;
      items_taken++;
      if (c == pts_pkg::CMD_LOAD_WEIGHT) begin
        weights[wi] = iv;
      end else if (c == pts_pkg::CMD_LOAD_BIAS) begin
        bias_reg = iv;
      end else if (c == pts_pkg::CMD_TRAIN) begin
        n = int'(count);
        if (n == 0) n = 1;
        if (n > MAXF) n = MAXF;
        pos = int'(fcount) % MAXF;
        feats[pos] = f;
        s = longint'(acc) + longint'(weights[pos]) * longint'(f);
        acc = s[pts_pkg::ACC_WIDTH-1:0];
        if (pos + 1 < n) begin
          fcount = 5'(pos + 1);
        end else begin
          s = longint'(acc) + longint'(bias_reg) * (longint'(1) << pts_pkg::FRAC_BITS);
          pred = ($signed(s[pts_pkg::ACC_WIDTH-1:0]) > 0) ? 1 : 0;
          err = int'(t) - pred;
          bias_reg = clamp(longint'(bias_reg)
                           + ((longint'(err) * longint'(rate))
                              >>> (pts_pkg::RATE_BITS - pts_pkg::FRAC_BITS)));
          for (i = 0; i <= pos; i++) begin
            p = longint'(err) * longint'(rate) * longint'(feats[i]);
            weights[i] = clamp(longint'(weights[i]) + (p >>> pts_pkg::RATE_BITS));
            u.idx = 4'(i);
            u.weight = weights[i];
            u.bias = bias_reg;
            u.pred = pred[0];
            u.err = 2'(err);
            u.last = (i == pos);
            expected_updates.push_back(u);
          end
          samples_done++;
          fcount = '0;
          acc = '0;
        end
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task match_update(logic [pts_pkg::INDEX_W-1:0] idx, logic signed [VW-1:0] w,
                      logic signed [VW-1:0] b, logic pr,
                      logic signed [pts_pkg::ERR_W-1:0] e, logic l);
      weight_update_t x;
      updates_seen++;
      if (expected_updates.size() == 0) begin
        flag_mismatch($sformatf("update idx %0d w %0d with nothing pending", idx, w));
        return;
      end
      x = expected_updates.pop_front();
      if (idx !== x.idx)
        flag_mismatch($sformatf("out_index %0d, want %0d", idx, x.idx));
      if (w !== x.weight)
        flag_mismatch($sformatf("idx %0d weight_value %0d, want %0d", x.idx, w, x.weight));
      if (b !== x.bias)
        flag_mismatch($sformatf("idx %0d bias_value %0d, want %0d", x.idx, b, x.bias));
      if (pr !== x.pred)
        flag_mismatch($sformatf("idx %0d prediction %b, want %b", x.idx, pr, x.pred));
      if (e !== x.err)
        flag_mismatch($sformatf("idx %0d error_value %0d, want %0d", x.idx, e, x.err));
      if (l !== x.last)
        flag_mismatch($sformatf("idx %0d last_result %b, want %b", x.idx, l, x.last));
    endtask

    task drain_check();
      weight_update_t x;
      while (expected_updates.size() != 0) begin
        x = expected_updates.pop_front();
        flag_mismatch($sformatf("update idx %0d never arrived", x.idx));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  logic [pts_pkg::CMD_W-1:0]        cmd = pts_pkg::CMD_TRAIN;
  logic signed [VW-1:0]             feature_value = '0;
  logic                             target = 1'b0;
  logic [pts_pkg::INDEX_W-1:0]      weight_index = '0;
  logic signed [VW-1:0]             init_value = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [pts_pkg::INDEX_W-1:0]      out_index;
  logic signed [VW-1:0]             weight_value;
  logic signed [VW-1:0]             bias_value;
  logic                             prediction;
  logic signed [pts_pkg::ERR_W-1:0] error_value;
  logic                             last_result;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [pts_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [pts_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  weight_update_tracker tracker = new();

  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_off_req = 1'b0;
  int  idle_cycles = 0;
  int  stall_tick = 0;
  int  stall_mode = 0;

  perceptron_training_step dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      tracker.take_item(cmd, feature_value, target, weight_index, init_value);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.match_update(out_index, weight_value, bias_value, prediction, error_value,
                           last_result);
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready)
      tracker.set_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: switches between randomly drawn stall patterns; a requested hold-off blocks
  // the result side long enough for the block to back up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall_tick++;
        if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: begin
            result_stall <= 1'b0;
          end
          1: begin
            result_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            result_stall <= 1'($urandom_range(0, 1));
          end
          default: begin
            result_stall <= ($urandom_range(0, 9) != 0);
          end
        endcase
      end
    end
  end

  function automatic logic signed [VW-1:0] pick_value();
    int v;
    if ($urandom_range(0, 2) == 0) begin
      v = $urandom_range(0, 8192) - 4096;
      return v[VW-1:0];
    end
    return 16'($urandom);
  endfunction

  task automatic send_item(logic [pts_pkg::CMD_W-1:0] c, logic signed [VW-1:0] f, logic t,
                           logic [pts_pkg::INDEX_W-1:0] wi, logic signed [VW-1:0] iv);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    item_valid <= 1'b1;
    cmd <= c;
    feature_value <= f;
    target <= t;
    weight_index <= wi;
    init_value <= iv;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_random_item();
    int r;
    logic [pts_pkg::CMD_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 5) c = CMD_UNUSED;
    else if (r < 12) c = pts_pkg::CMD_LOAD_WEIGHT;
    else if (r < 15) c = pts_pkg::CMD_LOAD_BIAS;
    else c = pts_pkg::CMD_TRAIN;
    send_item(c, pick_value(), 1'($urandom), 4'($urandom), pick_value());
  endtask

  // Drop valid, wait out every pending update, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    burst_left = 0;
    while (tracker.expected_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [pts_pkg::CFG_INDEX_W-1:0] idx,
                           logic [pts_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [pts_pkg::COUNT_W-1:0] phase_count(int ph);
    case (ph)
      0: return 5'd3;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd4;
      4: return 5'd31;
      5: return 5'd2;
      6: return 5'd17;
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [pts_pkg::RATE_W-1:0] phase_rate(int ph);
    case (ph % 4)
      0: return 16'hffff;
      1: return 16'($urandom);
      2: return pts_pkg::RATE_RESET;
      default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom_range(1, 4096));
    endcase
  endfunction

  initial begin
    int phase;
    int i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults after reset: rate 0.1, two features
    send_item(CMD_UNUSED, 16'sh7fff, 1'b1, 4'hf, 16'sh8000);
    send_item(pts_pkg::CMD_LOAD_WEIGHT, 16'sh0000, 1'b0, 4'd0, 16'sh7fff);
    send_item(pts_pkg::CMD_LOAD_WEIGHT, 16'sh0000, 1'b0, 4'd1, 16'sh8000);
    send_item(pts_pkg::CMD_LOAD_BIAS, 16'sh0000, 1'b0, 4'd0, 16'sh8000);
    send_item(pts_pkg::CMD_TRAIN, 16'sh7fff, 1'b1, 4'd0, 16'sh0000);
    send_item(pts_pkg::CMD_TRAIN, 16'sh8000, 1'b1, 4'd0, 16'sh0000);
    send_item(pts_pkg::CMD_TRAIN, 16'sh8000, 1'b0, 4'd0, 16'sh0000);
    send_item(pts_pkg::CMD_TRAIN, 16'sh7fff, 1'b1, 4'd0, 16'sh0000);

    settle();
    cfg_write(pts_pkg::REG_STEP_RATE, 16'hffff);
    cfg_write(pts_pkg::REG_FEATURE_COUNT, 16'd1);
    // bias saturates high, then low
    send_item(pts_pkg::CMD_LOAD_WEIGHT, 16'sh0000, 1'b0, 4'd0, 16'sh7fff);
    send_item(pts_pkg::CMD_LOAD_BIAS, 16'sh0000, 1'b0, 4'd0, 16'sh7fff);
    send_item(pts_pkg::CMD_TRAIN, 16'sh8000, 1'b1, 4'd0, 16'sh0000);
    send_item(pts_pkg::CMD_LOAD_WEIGHT, 16'sh0000, 1'b0, 4'd0, 16'sh7fff);
    send_item(pts_pkg::CMD_LOAD_BIAS, 16'sh0000, 1'b0, 4'd0, 16'sh8000);
    send_item(pts_pkg::CMD_TRAIN, 16'sh7fff, 1'b0, 4'd0, 16'sh0000);

    // a count of zero behaves as one; zero rate leaves weights in place
    settle();
    cfg_write(pts_pkg::REG_FEATURE_COUNT, 16'd0);
    cfg_write(pts_pkg::REG_STEP_RATE, 16'h0000);
    send_item(pts_pkg::CMD_TRAIN, 16'sh1234, 1'b1, 4'd0, 16'sh0000);
    send_item(pts_pkg::CMD_TRAIN, 16'shffff, 1'b0, 4'd0, 16'sh0000);

    // lower the count after five features of an eight-feature sample
    settle();
    cfg_write(pts_pkg::REG_FEATURE_COUNT, 16'd8);
    cfg_write(pts_pkg::REG_STEP_RATE, pts_pkg::RATE_RESET);
    for (i = 0; i < 5; i++)
      send_item(pts_pkg::CMD_TRAIN, pick_value(), 1'b0, 4'd0, 16'sh0000);
    settle();
    cfg_write(pts_pkg::REG_FEATURE_COUNT, 16'd3);
    cfg_write(REG_UNUSED, 16'hffff);
    send_item(pts_pkg::CMD_TRAIN, pick_value(), 1'b1, 4'd0, 16'sh0000);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      cfg_write(pts_pkg::REG_STEP_RATE, phase_rate(phase));
      cfg_write(pts_pkg::REG_FEATURE_COUNT, {11'($urandom), phase_count(phase)});
      gaps_on = (phase != 5);
      if (phase == 1) hold_off_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++)
        send_random_item();
    end

    settle();
    tracker.drain_check();
    $display("covered %0d items, %0d samples, %0d weight updates checked",
             tracker.items_taken, tracker.samples_done, tracker.updates_seen);
    $display("%0d register writes across %0d setting phases, one long result hold-off",
             tracker.reg_writes, PHASES + 4);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/pts_pkg.sv
hdl/pts_ram.sv
hdl/pts_ctrl.sv
hdl/pts_datapath.sv
hdl/perceptron_training_step.sv
hdl/pts_checker.sv
tb/sv/perceptron_training_step_tb.sv
